### src/stwd_pkg.sv
package stwd_pkg;

    // Field widths of the input and result transactions.
    localparam int OP_W     = 2;
    localparam int LIDX_W   = 8;
    localparam int WEIGHT_W = 40;
    localparam int PROBE_W  = 48;
    localparam int STATUS_W = 2;
    localparam int REMAIN_W = 40;
    localparam int TOTAL_W  = 48;

    // Stream widths: tdata rounded up to whole bytes, tuser holds the code only.
    localparam int TDATA_W = ((LIDX_W + WEIGHT_W + PROBE_W + 7) / 8) * 8;
    localparam int TUSER_W = OP_W;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Operation codes carried on s_tuser.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_DRAW  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Result status codes carried on m_tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // A classified command as it waits in the queue.
    typedef struct packed {
        op_t                 op;
        logic [LIDX_W-1:0]   leaf_index;
        logic [WEIGHT_W-1:0] weight;
        logic [PROBE_W-1:0]  probe;
        logic                probe_zero;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        status_t             status;
        logic [LIDX_W-1:0]   drawn_leaf;
        logic [REMAIN_W-1:0] leaf_remaining;
        logic [TOTAL_W-1:0]  total_remaining;
    } result_t;

    // What the back end is doing, for observation at the top level.
    typedef struct packed {
        logic clearing;
        logic building;
        logic drawing;
    } back_status_t;

endpackage

### src/stwd_front.sv
module stwd_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stwd_pkg::TDATA_W-1:0]  s_tdata,
    input  logic [stwd_pkg::TUSER_W-1:0]  s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output stwd_pkg::cmd_t                q_cmd
);

    // Accept whenever the queue has a free slot.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Unpack the transaction and classify it.
    always_comb begin
        q_cmd.op         = stwd_pkg::op_t'(s_tuser[stwd_pkg::OP_W-1:0]);
        q_cmd.leaf_index = s_tdata[stwd_pkg::LIDX_W-1:0];
        q_cmd.weight     = s_tdata[stwd_pkg::LIDX_W +: stwd_pkg::WEIGHT_W];
        q_cmd.probe      = s_tdata[stwd_pkg::LIDX_W + stwd_pkg::WEIGHT_W +: stwd_pkg::PROBE_W];
        q_cmd.probe_zero = (q_cmd.probe == '0);
    end

endmodule

### src/stwd_queue.sv
module stwd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  stwd_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop,
    output stwd_pkg::cmd_t pop_cmd
);

    stwd_pkg::cmd_t                entry_reg [stwd_pkg::QUEUE_DEPTH];
    logic [stwd_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [stwd_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [stwd_pkg::QPTR_W:0]     count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full      = (count_reg == (stwd_pkg::QPTR_W + 1)'(stwd_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/stwd_back.sv
module stwd_back #(
    parameter int LEAVES    = 256,
    parameter int NODE_BITS = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cmd_valid,
    input  stwd_pkg::cmd_t         cmd,
    output logic                   cmd_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output stwd_pkg::result_t      result,
    output stwd_pkg::back_status_t status
);

    localparam int LEAF_BITS = $clog2(LEAVES);
    localparam int NIDX_W    = LEAF_BITS + 1;
    localparam int CMP_W     = (NODE_BITS > stwd_pkg::PROBE_W) ? NODE_BITS : stwd_pkg::PROBE_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BLD_RD,
        S_BLD_WR,
        S_DRW_RD,
        S_DRW_WR
    } state_t;

    // Tree store: node 1 is the root, leaves sit at LEAVES and above.
    logic [NODE_BITS-1:0] node_mem [2*LEAVES];
    logic [NODE_BITS-1:0] rd_a_reg;
    logic [NODE_BITS-1:0] rd_b_reg;
    logic [NIDX_W-1:0]    addr_a;
    logic [NIDX_W-1:0]    addr_b;
    logic                 wr_en;
    logic [NIDX_W-1:0]    wr_addr;
    logic [NODE_BITS-1:0] wr_data;

    state_t               state_reg,     state_next;
    logic [NIDX_W-1:0]    node_reg,      node_next;
    logic [NODE_BITS-1:0] probe_reg,     probe_next;
    logic [NODE_BITS-1:0] root_reg,      root_next;
    logic                 out_valid_reg, out_valid_next;
    stwd_pkg::result_t    out_reg,       out_next;

    logic                 take;
    logic [NIDX_W-1:0]    leaf_node;
    logic [NIDX_W-1:0]    left_child;
    logic [NODE_BITS-1:0] dec_val;
    logic [NODE_BITS-1:0] sum_val;
    logic                 go_right;
    logic                 probe_high;

    assign take       = cmd_valid && (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign cmd_ready  = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign leaf_node  = {1'b1, LEAF_BITS'(cmd.leaf_index)};
    assign left_child = {node_reg[LEAF_BITS-1:0], 1'b0};
    assign dec_val    = (rd_a_reg != '0) ? rd_a_reg - 1'b1 : '0;
    assign sum_val    = rd_a_reg + rd_b_reg;
    assign go_right   = (probe_reg > rd_b_reg);
    assign probe_high = (CMP_W'(cmd.probe) > CMP_W'(root_reg));

    assign m_tvalid        = out_valid_reg;
    assign result          = out_reg;
    assign status.clearing = (state_reg == S_CLEAR);
    assign status.building = (state_reg == S_BLD_RD) || (state_reg == S_BLD_WR);
    assign status.drawing  = (state_reg == S_DRW_RD) || (state_reg == S_DRW_WR);

    // Sequencer: clearing pass, leaf loads, build sweep and the root-to-leaf walk.
    always_comb begin
        state_next     = state_reg;
        node_next      = node_reg;
        probe_next     = probe_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = node_reg;
        wr_data        = '0;
        addr_a         = node_reg;
        addr_b         = left_child;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                wr_en     = 1'b1;
                node_next = node_reg + 1'b1;
                if (&node_reg) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (take) begin
                    out_next.status          = stwd_pkg::ST_OK;
                    out_next.drawn_leaf      = '0;
                    out_next.leaf_remaining  = '0;
                    out_next.total_remaining = stwd_pkg::TOTAL_W'(root_reg);
                    out_valid_next           = 1'b1;
                    case (cmd.op)
                        stwd_pkg::OP_LOAD: begin
                            wr_en   = 1'b1;
                            wr_addr = leaf_node;
                            wr_data = NODE_BITS'(cmd.weight);
                        end
                        stwd_pkg::OP_BUILD: begin
                            out_valid_next = 1'b0;
                            node_next      = {1'b0, {LEAF_BITS{1'b1}}};
                            state_next     = S_BLD_RD;
                        end
                        stwd_pkg::OP_DRAW: begin
                            if (root_reg == '0) begin
                                out_next.status = stwd_pkg::ST_EMPTY;
                            end else if (cmd.probe_zero || probe_high) begin
                                out_next.status = stwd_pkg::ST_RANGE;
                            end else begin
                                out_valid_next = 1'b0;
                                probe_next     = NODE_BITS'(cmd.probe);
                                node_next      = NIDX_W'(1);
                                state_next     = S_DRW_RD;
                            end
                        end
                        default: begin
                            // Unused operation code: report the root only.
                        end
                    endcase
                end
            end

            S_BLD_RD: begin
                addr_a     = {node_reg[LEAF_BITS-1:0], 1'b0};
                addr_b     = {node_reg[LEAF_BITS-1:0], 1'b1};
                state_next = S_BLD_WR;
            end

            S_BLD_WR: begin
                wr_en   = 1'b1;
                wr_data = sum_val;
                if (node_reg == NIDX_W'(1)) begin
                    root_next                = sum_val;
                    out_next.status          = stwd_pkg::ST_OK;
                    out_next.drawn_leaf      = '0;
                    out_next.leaf_remaining  = '0;
                    out_next.total_remaining = stwd_pkg::TOTAL_W'(sum_val);
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end else begin
                    node_next  = node_reg - 1'b1;
                    state_next = S_BLD_RD;
                end
            end

            S_DRW_RD: begin
                state_next = S_DRW_WR;
            end

            S_DRW_WR: begin
                // Decrement the current node, then pick a child by the left sum.
                wr_en   = 1'b1;
                wr_data = dec_val;
                if (node_reg == NIDX_W'(1)) begin
                    root_next = dec_val;
                end
                if (node_reg[LEAF_BITS]) begin
                    out_next.status          = stwd_pkg::ST_OK;
                    out_next.drawn_leaf      = stwd_pkg::LIDX_W'(node_reg[LEAF_BITS-1:0]);
                    out_next.leaf_remaining  = stwd_pkg::REMAIN_W'(dec_val);
                    out_next.total_remaining = stwd_pkg::TOTAL_W'(root_reg);
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end else begin
                    if (go_right) begin
                        probe_next = probe_reg - rd_b_reg;
                        node_next  = {node_reg[LEAF_BITS-1:0], 1'b1};
                    end else begin
                        node_next  = left_child;
                    end
                    state_next = S_DRW_RD;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            node_reg      <= '0;
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
        probe_reg <= probe_next;
        out_reg   <= out_next;
    end

    // Tree memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= node_mem[addr_a];
        rd_b_reg <= node_mem[addr_b];
    end

endmodule

### src/sum_tree_weighted_draw.sv
// Channel  Direction  tdata (low bit first)                          tuser
// s_       in         leaf_index[7:0] weight[47:8] probe[95:48]     operation[1:0]
// m_       out        drawn_leaf[7:0] leaf_remaining[47:8]           status[1:0]
//                     total_remaining[95:48]
//
// Each item is taken by the back end when idle; loads, unused codes and refused draws end there.
// A build reads both children and writes their sum for each internal node, root last.
// A draw reads and writes back one less at each level from the root down to the drawn leaf.
// After reset a clearing pass writes zero to all 2*LEAVES nodes, one per cycle, before any
// item is taken. The two-entry queue goes on accepting until it is full while the back end
// works or its result waits on m_tready.
module sum_tree_weighted_draw #(
    parameter int LEAVES    = 256,
    parameter int NODE_BITS = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stwd_pkg::TDATA_W-1:0]  s_tdata,  // leaf_index, weight, probe
    input  logic [stwd_pkg::TUSER_W-1:0]  s_tuser,  // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stwd_pkg::TDATA_W-1:0]  m_tdata,  // drawn_leaf, leaf_remaining, total_remaining
    output logic [stwd_pkg::TUSER_W-1:0]  m_tuser   // status
);

    logic                   q_push;
    stwd_pkg::cmd_t         q_in;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    stwd_pkg::cmd_t         q_out;
    logic                   cmd_ready;
    stwd_pkg::result_t      result;
    stwd_pkg::back_status_t back_st;

    assign q_pop = q_valid && cmd_ready;

    // Front: accept and classify.
    stwd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    // Command queue between the two halves.
    stwd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_cmd   (q_out)
    );

    // Back: tree store and sequencer.
    stwd_back #(
        .LEAVES    (LEAVES),
        .NODE_BITS (NODE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (q_out),
        .cmd_ready (cmd_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result),
        .status    (back_st)
    );

    // Pack the result transaction.
    assign m_tdata = stwd_pkg::TDATA_W'({result.total_remaining, result.leaf_remaining,
                                         result.drawn_leaf});
    assign m_tuser = result.status;

    // No result is presented while the back end clears, builds or walks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (back_st.clearing || back_st.building || back_st.drawing) |-> !m_tvalid)
        else $error("result presented while back end busy");

    // A build command taken from the queue starts the build sweep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && (q_out.op == stwd_pkg::OP_BUILD)) |=> back_st.building)
        else $error("build command did not start the sweep");

    // A refused draw carries no leaf and no remaining count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != stwd_pkg::ST_OK)) |-> (m_tdata[47:0] == '0))
        else $error("refused draw reports a leaf");

    // An empty tree reports a zero total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == stwd_pkg::ST_EMPTY)) |-> (m_tdata[95:48] == '0))
        else $error("empty status with non-zero total");

endmodule

### verif/sum_tree_weighted_draw_tb.sv
`timescale 1ns / 1ps

module sum_tree_weighted_draw_tb;

    localparam int LEAVES      = 256;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 2000;
    localparam int TAIL_CYCLES = 600;
    localparam logic [stwd_pkg::WEIGHT_W-1:0] WEIGHT_MAX = '1;
    localparam logic [stwd_pkg::PROBE_W-1:0]  PROBE_MAX  = '1;
    // Root total after the directed loads of leaves 0, 128 and 255.
    localparam logic [stwd_pkg::TOTAL_W-1:0]  FIRST_TOTAL =
        stwd_pkg::TOTAL_W'(WEIGHT_MAX) + 48'd6;

    // One input transaction as the generator builds it.
    typedef struct packed {
        stwd_pkg::op_t                 op;
        logic [stwd_pkg::LIDX_W-1:0]   leaf;
        logic [stwd_pkg::WEIGHT_W-1:0] weight;
        logic [stwd_pkg::PROBE_W-1:0]  probe;
    } tree_cmd_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [stwd_pkg::TDATA_W-1:0]  s_tdata  = '0;
    logic [stwd_pkg::TUSER_W-1:0]  s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [stwd_pkg::TDATA_W-1:0]  m_tdata;
    logic [stwd_pkg::TUSER_W-1:0]  m_tuser;

    // Commands waiting to be offered, the one on the bus, and the results owed.
    tree_cmd_t         cmd_queue[$];
    tree_cmd_t         cmd_on_bus;
    stwd_pkg::result_t owed_results[$];
    stwd_pkg::result_t owed;

    // Predicted node counts; node 1 is the root, leaves sit at LEAVES and up.
    logic [stwd_pkg::TOTAL_W-1:0] node_count [0:2*LEAVES-1];

    // Generator view: leaf counts as last seen and the root it expects.
    logic [stwd_pkg::TOTAL_W-1:0] leaf_shadow [0:LEAVES-1];
    logic [stwd_pkg::TOTAL_W-1:0] est_total;

    int cycle      = 0;
    int err_cnt    = 0;
    int hold_left  = 0;
    int holds_done = 0;
    int gen_items  = 0;
    logic quiet;

    sum_tree_weighted_draw #(
        .LEAVES    (LEAVES),
        .NODE_BITS (stwd_pkg::TOTAL_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Cycle count and timeout.
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // A long window in which neither side idles.
    assign quiet = (cycle >= 20000) && (cycle < 30000);

    // Takes one from a node count; a count already at zero stays at zero.
    function automatic void take_one(int idx);
        if (node_count[idx] != 0) begin
            node_count[idx] = node_count[idx] - 1'b1;
        end
    endfunction

    // Applies one command to the predicted tree and returns the result it owes.
    function automatic stwd_pkg::result_t apply_cmd(tree_cmd_t c);
        stwd_pkg::result_t            r;
        logic [stwd_pkg::TOTAL_W-1:0] total;
        logic [stwd_pkg::TOTAL_W-1:0] p;
        int                           i;
        r = '0;
        r.status = stwd_pkg::ST_OK;
        case (c.op)
            stwd_pkg::OP_LOAD: begin
                node_count[LEAVES + (c.leaf % LEAVES)] = stwd_pkg::TOTAL_W'(c.weight);
            end
            stwd_pkg::OP_BUILD: begin
                for (i = LEAVES - 1; i > 0; i--) begin
                    node_count[i] = node_count[2*i] + node_count[2*i+1];
                end
            end
            stwd_pkg::OP_DRAW: begin
                total = node_count[1];
                p     = c.probe;
                if (total == 0) begin
                    r.status = stwd_pkg::ST_EMPTY;
                end else if (p == 0 || p > total) begin
                    r.status = stwd_pkg::ST_RANGE;
                end else begin
                    i = 1;
                    while (i < LEAVES) begin
                        take_one(i);
                        i = 2 * i;
                        if (p > node_count[i]) begin
                            p = p - node_count[i];
                            i = i + 1;
                        end
                    end
                    take_one(i);
                    r.drawn_leaf     = stwd_pkg::LIDX_W'(i - LEAVES);
                    r.leaf_remaining = stwd_pkg::REMAIN_W'(node_count[i]);
                end
            end
            default: begin
            end
        endcase
        r.total_remaining = node_count[1];
        return r;
    endfunction

    // Driver: predicts each accepted command, then offers the next one or idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                owed_results.insert(owed_results.size(), apply_cmd(cmd_on_bus));
            end
            if (cmd_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
                cmd_on_bus = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cmd_on_bus.probe, cmd_on_bus.weight, cmd_on_bus.leaf};
                s_tuser  <= cmd_on_bus.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off on the result side, started while commands are queued up.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && cycle > 2000 && cmd_queue.size() >= 10) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Monitor: checks each result transaction against the oldest one owed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result transaction with none owed: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    err_cnt++;
                end else begin
                    owed = owed_results.pop_front();
                    if (m_tuser != owed.status) begin
                        $error("status: expected %0d, got %0d", owed.status, m_tuser);
                        err_cnt++;
                    end
                    if (m_tdata[stwd_pkg::LIDX_W-1:0] != owed.drawn_leaf) begin
                        $error("drawn_leaf: expected %0d, got %0d",
                               owed.drawn_leaf, m_tdata[stwd_pkg::LIDX_W-1:0]);
                        err_cnt++;
                    end
                    if (m_tdata[stwd_pkg::LIDX_W +: stwd_pkg::REMAIN_W]
                            != owed.leaf_remaining) begin
                        $error("leaf_remaining: expected %0d, got %0d",
                               owed.leaf_remaining,
                               m_tdata[stwd_pkg::LIDX_W +: stwd_pkg::REMAIN_W]);
                        err_cnt++;
                    end
                    if (m_tdata[stwd_pkg::LIDX_W+stwd_pkg::REMAIN_W +: stwd_pkg::TOTAL_W]
                            != owed.total_remaining) begin
                        $error("total_remaining: expected %0d, got %0d",
                               owed.total_remaining,
                               m_tdata[stwd_pkg::LIDX_W+stwd_pkg::REMAIN_W +:
                                       stwd_pkg::TOTAL_W]);
                        err_cnt++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 12);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Weights spread over tiny, moderate, full-width and maximum values.
    function automatic logic [stwd_pkg::WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return stwd_pkg::WEIGHT_W'($urandom_range(0, 3));
            1:       return stwd_pkg::WEIGHT_W'($urandom_range(0, 1000));
            2:       return stwd_pkg::WEIGHT_W'(rand64());
            default: return stwd_pkg::WEIGHT_W'(WEIGHT_MAX);
        endcase
    endfunction

    // Probes mostly within the expected total, the rest zero, just above, at the maximum or wild.
    function automatic logic [stwd_pkg::PROBE_W-1:0] pick_probe();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80 && est_total != 0) begin
            return stwd_pkg::PROBE_W'((rand64() % 64'(est_total)) + 1);
        end else if (r < 85) begin
            return '0;
        end else if (r < 90) begin
            return est_total + 1'b1;
        end else if (r < 95) begin
            return PROBE_MAX;
        end else begin
            return stwd_pkg::PROBE_W'(rand64());
        end
    endfunction

    task automatic push_cmd(stwd_pkg::op_t op, logic [stwd_pkg::LIDX_W-1:0] leaf,
                            logic [stwd_pkg::WEIGHT_W-1:0] weight,
                            logic [stwd_pkg::PROBE_W-1:0] probe);
        tree_cmd_t c;
        c.op     = op;
        c.leaf   = leaf;
        c.weight = weight;
        c.probe  = probe;
        cmd_queue.insert(cmd_queue.size(), c);
        gen_items++;
    endtask

    task automatic load_leaf(logic [stwd_pkg::LIDX_W-1:0] leaf,
                             logic [stwd_pkg::WEIGHT_W-1:0] weight);
        push_cmd(stwd_pkg::OP_LOAD, leaf, weight, stwd_pkg::PROBE_W'(rand64()));
        leaf_shadow[leaf] = stwd_pkg::TOTAL_W'(weight);
    endtask

    // A build makes the root the sum of all leaves as the generator sees them.
    task automatic build_tree();
        int i;
        push_cmd(stwd_pkg::OP_BUILD, stwd_pkg::LIDX_W'($urandom),
                 stwd_pkg::WEIGHT_W'(rand64()), stwd_pkg::PROBE_W'(rand64()));
        est_total = '0;
        for (i = 0; i < LEAVES; i++) begin
            est_total = est_total + leaf_shadow[i];
        end
    endtask

    // A draw within the total takes exactly one from the root.
    task automatic push_draw(logic [stwd_pkg::PROBE_W-1:0] probe);
        push_cmd(stwd_pkg::OP_DRAW, stwd_pkg::LIDX_W'($urandom),
                 stwd_pkg::WEIGHT_W'(rand64()), probe);
        if (probe != 0 && probe <= est_total) begin
            est_total = est_total - 1'b1;
        end
    endtask

    task automatic draw_series(int n);
        int i;
        for (i = 0; i < n; i++) begin
            push_draw(pick_probe());
        end
    endtask

    task automatic fill_all(logic [stwd_pkg::WEIGHT_W-1:0] weight);
        int i;
        for (i = 0; i < LEAVES; i++) begin
            load_leaf(stwd_pkg::LIDX_W'(i), weight);
        end
        build_tree();
    endtask

    // Waits until nothing is queued, offered or owed, then takes up the
    // predicted leaf counts and root as the generator's starting point.
    task automatic wait_idle();
        int i;
        @(negedge aclk);
        while (cmd_queue.size() != 0 || s_tvalid || owed_results.size() != 0) begin
            @(negedge aclk);
        end
        for (i = 0; i < LEAVES; i++) begin
            leaf_shadow[i] = node_count[LEAVES + i];
        end
        est_total = node_count[1];
    endtask

    // Stimulus: directed cases first, then random phases of loads, builds and draws.
    initial begin
        int phase;
        int i;
        int n;
        for (i = 0; i < 2 * LEAVES; i++) begin
            node_count[i] = '0;
        end
        for (i = 0; i < LEAVES; i++) begin
            leaf_shadow[i] = '0;
        end
        est_total = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty tree, an unused code and a build over nothing.
        push_draw(48'd1);
        push_cmd(stwd_pkg::OP_NOP, 8'h5a, 40'h12_3456_789a, 48'h0000_ffff_0000);
        build_tree();
        // Extreme leaves and weights; a draw before any build still sees an empty root.
        load_leaf(8'd0, WEIGHT_MAX);
        load_leaf(8'd255, 40'd5);
        load_leaf(8'd128, 40'd1);
        push_draw(48'd1);
        build_tree();
        // Probe of zero, one above the total and at its maximum; then the edges.
        push_draw(48'd0);
        push_draw(FIRST_TOTAL + 1'b1);
        push_draw(PROBE_MAX);
        push_draw(FIRST_TOTAL);
        push_draw(48'd1);
        push_draw(FIRST_TOTAL - 48'd2);
        // Stale sums: loads without a build, including a leaf emptied under the walk.
        load_leaf(8'd128, 40'd1000);
        push_draw(48'h00ff_ffff_ffff);
        load_leaf(8'd0, 40'd0);
        push_draw(48'd1);
        push_draw(48'd2);
        build_tree();
        push_draw(48'd1);
        push_cmd(stwd_pkg::OP_NOP, '1, '1, '1);
        push_draw(est_total);

        // Every leaf at its maximum weight, so the root comes close to full width.
        wait_idle();
        fill_all(WEIGHT_MAX);
        push_draw(PROBE_MAX);
        push_draw(est_total);
        push_draw(48'd1);
        draw_series(10);

        phase = 1;
        while (gen_items < RAND_ITEMS) begin
            wait_idle();
            if (phase % 25 == 0) begin
                // Empty the tree, then draw a small tree down to nothing.
                fill_all('0);
                push_draw(48'd1);
                load_leaf(stwd_pkg::LIDX_W'($urandom), 40'd1);
                load_leaf(stwd_pkg::LIDX_W'($urandom), 40'd2);
                build_tree();
                draw_series(5);
                push_draw(48'd1);
            end else begin
                case ($urandom_range(0, 9))
                    7: begin
                        // Loads left stale, draws walk the old sums.
                        n = $urandom_range(1, 4);
                        for (i = 0; i < n; i++) begin
                            load_leaf(stwd_pkg::LIDX_W'($urandom), pick_weight());
                        end
                        draw_series($urandom_range(2, 10));
                    end
                    8, 9: begin
                        // Unstructured noise over every code and every field bit.
                        n = $urandom_range(5, 20);
                        for (i = 0; i < n; i++) begin
                            push_cmd(stwd_pkg::op_t'($urandom_range(0, 3)),
                                     stwd_pkg::LIDX_W'($urandom),
                                     stwd_pkg::WEIGHT_W'(rand64()),
                                     stwd_pkg::PROBE_W'(rand64()));
                        end
                    end
                    default: begin
                        // Well-formed: a few loads, a build, then a run of draws.
                        n = $urandom_range(1, 8);
                        for (i = 0; i < n; i++) begin
                            load_leaf(stwd_pkg::LIDX_W'($urandom), pick_weight());
                            if ($urandom_range(0, 9) == 0) begin
                                push_cmd(stwd_pkg::OP_NOP, stwd_pkg::LIDX_W'($urandom),
                                         stwd_pkg::WEIGHT_W'(rand64()),
                                         stwd_pkg::PROBE_W'(rand64()));
                            end
                        end
                        build_tree();
                        draw_series($urandom_range(4, 30));
                    end
                endcase
            end
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && owed_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
src/stwd_pkg.sv
src/stwd_front.sv
src/stwd_queue.sv
src/stwd_back.sv
src/sum_tree_weighted_draw.sv
verif/sum_tree_weighted_draw_tb.sv
